// File: rtl/bcs_pkg.sv
// Package for the box collision snap block: widths, operation codes,
// transaction structs and the sign-extension and saturation helpers.
// Used by every module of the block; it depends on nothing.
`timescale 1ns / 1ps

package bcs_pkg;

  localparam int COORD_W = 32;
  localparam int FRACT_W = 32;
  localparam int EXT_W   = COORD_W + 2;

  localparam logic signed [EXT_W-1:0] C_MAX = {3'b000, {(COORD_W-1){1'b1}}};
  localparam logic signed [EXT_W-1:0] C_MIN = {3'b111, {(COORD_W-1){1'b0}}};

  localparam logic [1:0] ACT_MOVER    = 2'd0;
  localparam logic [1:0] ACT_PREV     = 2'd1;
  localparam logic [1:0] ACT_OBSTACLE = 2'd2;
  localparam logic       KIND_SECTOR  = 1'b0;

  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_MOVER  = 3'd1,
    OP_PREV   = 3'd2,
    OP_SECTOR = 3'd3,
    OP_BODY   = 3'd4
  } op_t;

  typedef struct packed {
    logic [1:0]                action;
    logic                      obstacle_kind;
    logic signed [COORD_W-1:0] word_0;
    logic signed [COORD_W-1:0] word_1;
    logic signed [COORD_W-1:0] word_2;
    logic signed [COORD_W-1:0] word_3;
    logic signed [COORD_W-1:0] word_4;
    logic signed [COORD_W-1:0] word_5;
    logic signed [FRACT_W-1:0] friction_in;
    logic                      is_rect;
    logic                      last;
  } item_t;

  typedef struct packed {
    logic                      collided;
    logic signed [COORD_W-1:0] snap_x;
    logic signed [COORD_W-1:0] snap_y;
    logic signed [COORD_W-1:0] snap_z;
    logic signed [FRACT_W-1:0] friction_out;
  } result_t;

  typedef struct packed {
    op_t                     op;
    logic [5:0][COORD_W-1:0] w;
    logic [FRACT_W-1:0]      fric;
    logic                    rect;
    logic                    last;
  } entry_t;

  typedef struct packed {
    op_t                     op;
    logic                    hit;
    logic                    snap_en;
    logic [2:0]              up;
    logic [2:0]              down;
    logic [2:0][EXT_W-1:0]   cand;
    logic [2:0][COORD_W-1:0] pos;
    logic [FRACT_W-1:0]      fric;
    logic                    last;
  } stage_t;

  function automatic logic signed [EXT_W-1:0] ext(input logic [COORD_W-1:0] v);
    ext = $signed({{2{v[COORD_W-1]}}, v});
  endfunction

  function automatic logic [COORD_W-1:0] sat(input logic signed [EXT_W-1:0] v);
    logic signed [EXT_W-1:0] r;
    r = v;
    if (v > C_MAX) begin
      r = C_MAX;
    end else if (v < C_MIN) begin
      r = C_MIN;
    end
    sat = r[COORD_W-1:0];
  endfunction

endpackage

// File: rtl/bcs_front.sv
// Front end of the box collision snap block: accepts input transactions
// and classifies each one into an operation for the queue.
// Depends on bcs_pkg.
`timescale 1ns / 1ps

module bcs_front
  import bcs_pkg::*;
(
  input  logic   rst,
  input  logic   item_valid,
  output logic   item_stall,
  input  item_t  item,
  input  logic   q_full,
  output logic   push,
  output entry_t entry
);

  op_t op;

  always_comb begin
    case (item.action)
      ACT_MOVER:    op = OP_MOVER;
      ACT_PREV:     op = OP_PREV;
      ACT_OBSTACLE: op = (item.obstacle_kind == KIND_SECTOR) ? OP_SECTOR : OP_BODY;
      default:      op = OP_NONE;
    endcase
  end

  assign item_stall = q_full || rst;
  assign push       = item_valid && !item_stall;

  always_comb begin
    entry.op   = op;
    entry.w[0] = item.word_0;
    entry.w[1] = item.word_1;
    entry.w[2] = item.word_2;
    entry.w[3] = item.word_3;
    entry.w[4] = item.word_4;
    entry.w[5] = item.word_5;
    entry.fric = item.friction_in;
    entry.rect = item.is_rect;
    entry.last = item.last;
  end

endmodule

// File: rtl/bcs_queue.sv
// Two-entry queue between the front end and the back end of the
// box collision snap block. Depends on bcs_pkg.
`timescale 1ns / 1ps

module bcs_queue
  import bcs_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t wr_entry,
  input  logic   pop,
  output logic   full,
  output logic   head_valid,
  output entry_t head
);

  entry_t     mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// File: rtl/bcs_back.sv
// Back end of the box collision snap block: the overlap test and face
// selection stage, the snap and friction update stage, and the result
// register. Depends on bcs_pkg.
`timescale 1ns / 1ps

module bcs_back
  import bcs_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    head_valid,
  input  entry_t  head,
  output logic    pop,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  logic [2:0][COORD_W-1:0] mover_pos;
  logic [2:0][COORD_W-1:0] mover_half;
  logic [2:0][COORD_W-1:0] prev_pos;
  logic [2:0][COORD_W-1:0] snap_pos;
  logic [FRACT_W-1:0]      max_friction;
  logic                    hit_flag;

  stage_t stg;
  stage_t stg_next;
  logic   stg_valid;
  logic   stg_advance;

  logic [2:0][COORD_W-1:0] snap_pos_next;
  logic [FRACT_W-1:0]      max_friction_next;
  logic                    hit_flag_next;

  assign stg_advance = stg_valid && !(stg.last && result_valid && result_stall);
  assign pop         = head_valid && (!stg_valid || stg_advance);

  always_comb begin
    logic signed [EXT_W-1:0] p [3];
    logic signed [EXT_W-1:0] h [3];
    logic signed [EXT_W-1:0] pv [3];
    logic signed [EXT_W-1:0] w [6];
    logic signed [EXT_W-1:0] lo [3];
    logic signed [EXT_W-1:0] hi [3];
    logic signed [EXT_W-1:0] d;
    logic signed [EXT_W-1:0] s;
    logic                    z_inside;
    logic                    sec_miss;
    logic                    body_hit;
    for (int a = 0; a < 3; a++) begin
      p[a]  = ext(mover_pos[a]);
      h[a]  = ext(mover_half[a]);
      pv[a] = ext(prev_pos[a]);
    end
    for (int i = 0; i < 6; i++) begin
      w[i] = ext(head.w[i]);
    end
    z_inside = (p[2] - h[2] >= w[4]) && (p[2] + h[2] <= w[5]);
    sec_miss = z_inside || (p[0] - h[0] >= w[1]) || (p[0] + h[0] <= w[0])
               || (p[1] - h[1] >= w[3]) || (p[1] + h[1] <= w[2]);
    body_hit = 1'b1;
    for (int a = 0; a < 3; a++) begin
      d = p[a] - w[a];
      s = h[a] + w[a+3];
      if (!((d < s) && (-d < s))) begin
        body_hit = 1'b0;
      end
    end
    if (head.op == OP_SECTOR) begin
      lo[0] = w[0];
      hi[0] = w[1];
      lo[1] = w[2];
      hi[1] = w[3];
      lo[2] = w[5];
      hi[2] = w[4];
    end else begin
      for (int a = 0; a < 3; a++) begin
        lo[a] = w[a] - w[a+3];
        hi[a] = w[a] + w[a+3];
      end
    end
    stg_next.op      = head.op;
    stg_next.hit     = (head.op == OP_SECTOR) ? !sec_miss :
                       (head.op == OP_BODY) ? body_hit : 1'b0;
    stg_next.snap_en = (head.op == OP_BODY) || head.rect;
    for (int a = 0; a < 3; a++) begin
      stg_next.up[a]   = pv[a] < p[a];
      stg_next.down[a] = pv[a] > p[a];
      stg_next.cand[a] = (pv[a] < p[a]) ? lo[a] - h[a] : hi[a] + h[a];
      stg_next.pos[a]  = head.w[a];
    end
    stg_next.fric = head.fric;
    stg_next.last = head.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mover_pos  <= '0;
      mover_half <= '0;
      prev_pos   <= '0;
      stg_valid  <= 1'b0;
    end else begin
      if (pop) begin
        stg_valid <= 1'b1;
        if (head.op == OP_MOVER) begin
          for (int a = 0; a < 3; a++) begin
            mover_pos[a]  <= head.w[a];
            mover_half[a] <= head.w[a+3];
          end
        end
        if (head.op == OP_PREV) begin
          for (int a = 0; a < 3; a++) begin
            prev_pos[a] <= head.w[a];
          end
        end
      end else if (stg_advance) begin
        stg_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      stg <= stg_next;
    end
  end

  always_comb begin
    logic signed [EXT_W-1:0] cur;
    cur               = '0;
    snap_pos_next     = snap_pos;
    max_friction_next = max_friction;
    hit_flag_next     = hit_flag;
    if (stg.op == OP_MOVER) begin
      snap_pos_next     = stg.pos;
      max_friction_next = stg.fric;
      hit_flag_next     = 1'b0;
    end else if (stg.hit) begin
      if (stg.snap_en) begin
        for (int a = 0; a < 3; a++) begin
          cur = ext(snap_pos[a]);
          if (stg.up[a] && $signed(stg.cand[a]) < cur) begin
            cur = $signed(stg.cand[a]);
          end
          if (stg.down[a] && $signed(stg.cand[a]) > cur) begin
            cur = $signed(stg.cand[a]);
          end
          snap_pos_next[a] = sat(cur);
        end
      end
      if ($signed(max_friction) < $signed(stg.fric)) begin
        max_friction_next = stg.fric;
      end
      hit_flag_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_pos     <= '0;
      max_friction <= '0;
      hit_flag     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (stg_advance) begin
        snap_pos     <= snap_pos_next;
        max_friction <= max_friction_next;
        hit_flag     <= hit_flag_next;
      end
      if (stg_advance && stg.last) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stg_advance && stg.last) begin
      result.collided     <= hit_flag_next;
      result.snap_x       <= snap_pos_next[0];
      result.snap_y       <= snap_pos_next[1];
      result.snap_z       <= snap_pos_next[2];
      result.friction_out <= max_friction_next;
    end
  end

endmodule

// File: rtl/box_collision_snap.sv
// Top level of the box collision snap block: front end, queue and back end.
// Depends on bcs_pkg, bcs_front, bcs_queue and bcs_back.
//
// Usage: the item channel (item_valid, item_stall, item) carries one
// transaction per item: a mover load, a previous position load or one
// obstacle, either a sector box or another body. The result channel
// (result_valid, result_stall, result) returns one transaction for every
// item marked last, holding the collided flag, the snap position and the
// largest friction of the last mover load and of the obstacles hit since it.
// One item is accepted per cycle while item_stall is low. The last item of a
// result passes from the queue into the test stage register and then sets the
// result register. A two-entry queue sits between the front end and the back
// end; the back end holds a test stage and an update stage.
// While result_stall is high the result register holds its transaction;
// items keep flowing until an item marked last reaches the update stage,
// and then the queue fills and item_stall rises.
// Synchronous reset clears the mover, previous and snap positions, the
// friction and the collided flag to zero and empties the pipeline.
`timescale 1ns / 1ps

module box_collision_snap
  import bcs_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  logic   q_full;
  logic   push;
  logic   pop;
  logic   head_valid;
  entry_t wr_entry;
  entry_t head;

  bcs_front u_front (
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .q_full     (q_full),
    .push       (push),
    .entry      (wr_entry)
  );

  bcs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .wr_entry   (wr_entry),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  bcs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// File: tb/box_collision_snap_tb.sv
// Self-checking testbench for box_collision_snap: directed and random collision queries.
// A predictor computes each expected result, and a monitor compares every result transaction.
// Depends on bcs_pkg and the box_collision_snap RTL.
`timescale 1ns / 1ps

module box_collision_snap_tb;
  import bcs_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic       KIND_BODY  = 1'b1;
  localparam int         MAX_WAIT   = 17;
  localparam int         ITEM_GOAL  = 1600;
  localparam int         LIMIT      = 500000;
  localparam longint     COORD_HI   = 64'sd2147483647;
  localparam longint     COORD_LO   = -64'sd2147483648;

  logic    clk = 1'b0;
  logic    rst;
  logic    item_valid;
  logic    item_stall;
  item_t   item;
  logic    result_valid;
  logic    result_stall;
  result_t result;

  item_t   pending[$];
  result_t snaps_due[$];

  longint  mover_c[3];
  longint  mover_h[3];
  longint  prev_c[3];
  longint  snap_c[3];
  longint  top_friction;
  bit      any_hit;

  int      gap_left;
  int      hold_left;
  int      cycles;
  int      errors;
  int      items_queued;
  int      items_taken;
  int      results_seen;
  int      results_hit;
  bit      calm;

  box_collision_snap dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  always #5 clk = ~clk;

  function automatic longint sx(logic [31:0] v);
    return longint'($signed(v));
  endfunction

  function automatic int pick_wait();
    if (calm || $urandom_range(0, 2) == 0) begin
      return 0;
    end
    return $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic void pull_axis(int a, longint lo_face, longint hi_face);
    longint s;
    s = snap_c[a];
    if (prev_c[a] < mover_c[a] && lo_face - mover_h[a] < s) begin
      s = lo_face - mover_h[a];
    end
    if (prev_c[a] > mover_c[a] && hi_face + mover_h[a] > s) begin
      s = hi_face + mover_h[a];
    end
    if (s > COORD_HI) begin
      s = COORD_HI;
    end else if (s < COORD_LO) begin
      s = COORD_LO;
    end
    snap_c[a] = s;
  endfunction

  function automatic void note_hit(longint f);
    if (top_friction < f) begin
      top_friction = f;
    end
    any_hit = 1'b1;
  endfunction

  function automatic void track_collision(item_t it);
    longint  w[6];
    longint  f;
    longint  d;
    bit      clear;
    result_t r;
    w[0] = sx(it.word_0);
    w[1] = sx(it.word_1);
    w[2] = sx(it.word_2);
    w[3] = sx(it.word_3);
    w[4] = sx(it.word_4);
    w[5] = sx(it.word_5);
    f = sx(it.friction_in);
    if (it.action == ACT_MOVER) begin
      for (int a = 0; a < 3; a++) begin
        mover_c[a] = w[a];
        mover_h[a] = w[a + 3];
        snap_c[a] = w[a];
      end
      top_friction = f;
      any_hit = 1'b0;
    end else if (it.action == ACT_PREV) begin
      for (int a = 0; a < 3; a++) begin
        prev_c[a] = w[a];
      end
    end else if (it.action == ACT_OBSTACLE) begin
      if (it.obstacle_kind == KIND_SECTOR) begin
        clear = (mover_c[2] - mover_h[2] >= w[4] && mover_c[2] + mover_h[2] <= w[5]) ||
                mover_c[0] - mover_h[0] >= w[1] || mover_c[0] + mover_h[0] <= w[0] ||
                mover_c[1] - mover_h[1] >= w[3] || mover_c[1] + mover_h[1] <= w[2];
        if (!clear) begin
          if (it.is_rect) begin
            pull_axis(0, w[0], w[1]);
            pull_axis(1, w[2], w[3]);
            pull_axis(2, w[5], w[4]);
          end
          note_hit(f);
        end
      end else begin
        clear = 1'b0;
        for (int a = 0; a < 3; a++) begin
          d = mover_c[a] - w[a];
          if (d < 0) begin
            d = -d;
          end
          if (!(d < mover_h[a] + w[a + 3])) begin
            clear = 1'b1;
          end
        end
        if (!clear) begin
          for (int a = 0; a < 3; a++) begin
            pull_axis(a, w[a] - w[a + 3], w[a] + w[a + 3]);
          end
          note_hit(f);
        end
      end
    end
    if (it.last) begin
      r.collided = any_hit;
      r.snap_x = snap_c[0][31:0];
      r.snap_y = snap_c[1][31:0];
      r.snap_z = snap_c[2][31:0];
      r.friction_out = top_friction[31:0];
      snaps_due.push_back(r);
    end
  endfunction

  function automatic item_t mk(logic [1:0] act, logic kind, int w0, int w1, int w2, int w3,
                               int w4, int w5, int fr, logic rect, logic lst);
    item_t it;
    it.action = act;
    it.obstacle_kind = kind;
    it.word_0 = w0;
    it.word_1 = w1;
    it.word_2 = w2;
    it.word_3 = w3;
    it.word_4 = w4;
    it.word_5 = w5;
    it.friction_in = fr;
    it.is_rect = rect;
    it.last = lst;
    return it;
  endfunction

  function automatic void queue_item(item_t it);
    pending.push_back(it);
    if (it.action != ACT_UNUSED || it.last) begin
      items_queued++;
    end
  endfunction

  function automatic logic [31:0] near(logic [31:0] base, int span);
    return base + 32'($urandom_range(0, 2 * span)) - 32'(span);
  endfunction

  function automatic logic [31:0] pick_half(bit wide);
    if ($urandom_range(0, 19) == 0) begin
      return -32'($urandom_range(0, 50));
    end
    if (wide && $urandom_range(0, 1) == 0) begin
      return 32'($urandom_range(0, 32'h7fff_ffff));
    end
    return 32'($urandom_range(0, 300));
  endfunction

  function automatic void add_noise();
    item_t it;
    it.action = 2'($urandom_range(0, 3));
    it.obstacle_kind = 1'($urandom);
    it.word_0 = $urandom;
    it.word_1 = $urandom;
    it.word_2 = $urandom;
    it.word_3 = $urandom;
    it.word_4 = $urandom;
    it.word_5 = $urandom;
    it.friction_in = $urandom;
    it.is_rect = 1'($urandom);
    it.last = 1'($urandom);
    queue_item(it);
  endfunction

  function automatic void add_query();
    logic [31:0] c[3];
    logic [31:0] h[3];
    logic [31:0] p[3];
    logic [31:0] w[6];
    logic [31:0] fr;
    bit          wide;
    bit          lst;
    int          n;
    wide = ($urandom_range(0, 4) == 0);
    for (int a = 0; a < 3; a++) begin
      if (!wide) begin
        c[a] = near(32'd0, 2000);
      end else begin
        case ($urandom_range(0, 2))
          0: c[a] = 32'h8000_0000 + 32'($urandom_range(0, 4000));
          1: c[a] = 32'h7fff_ffff - 32'($urandom_range(0, 4000));
          default: c[a] = $urandom;
        endcase
      end
      h[a] = pick_half(wide);
      case ($urandom_range(0, 3))
        0: p[a] = c[a];
        1: p[a] = wide ? $urandom : near(c[a], 400);
        default: p[a] = near(c[a], 60);
      endcase
    end
    if ($urandom_range(0, 7) != 0) begin
      queue_item(mk(ACT_MOVER, 1'($urandom), c[0], c[1], c[2], h[0], h[1], h[2],
                    $urandom, 1'($urandom), 1'($urandom_range(0, 15) == 0)));
    end
    if ($urandom_range(0, 7) != 0) begin
      queue_item(mk(ACT_PREV, 1'($urandom), p[0], p[1], p[2], $urandom, $urandom,
                    $urandom, $urandom, 1'($urandom), 1'($urandom_range(0, 15) == 0)));
    end
    n = $urandom_range(1, 6);
    for (int k = 0; k < n; k++) begin
      fr = ($urandom_range(0, 1) == 0) ? $urandom : near(32'd0, 1000);
      lst = (k == n - 1) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 9) == 0);
      if ($urandom_range(0, 1) == 0) begin
        for (int a = 0; a < 3; a++) begin
          w[a] = near(c[a], 400);
          w[a + 3] = pick_half(wide);
        end
        queue_item(mk(ACT_OBSTACLE, KIND_BODY, w[0], w[1], w[2], w[3], w[4], w[5],
                      fr, 1'($urandom), lst));
      end else begin
        w[0] = near(c[0], 500);
        w[1] = w[0] + 32'($urandom_range(0, 900));
        w[2] = near(c[1], 500);
        w[3] = w[2] + 32'($urandom_range(0, 900));
        if ($urandom_range(0, 2) == 0) begin
          w[4] = c[2] - h[2] - 32'($urandom_range(0, 20));
          w[5] = c[2] + h[2] + 32'($urandom_range(0, 20));
        end else begin
          w[4] = near(c[2], 400);
          w[5] = w[4] + 32'($urandom_range(0, 700));
        end
        queue_item(mk(ACT_OBSTACLE, KIND_SECTOR, w[0], w[1], w[2], w[3], w[4], w[5],
                      fr, 1'($urandom_range(0, 4) != 0), lst));
      end
    end
  endfunction

  function automatic void check_result(result_t got);
    result_t want;
    results_seen++;
    if (got.collided) begin
      results_hit++;
    end
    if (snaps_due.size() == 0) begin
      $display("%0t: unexpected result %p", $time, got);
      errors++;
      return;
    end
    want = snaps_due.pop_front();
    if (got.collided !== want.collided) begin
      $display("%0t: collided expected %0b actual %0b", $time, want.collided, got.collided);
      errors++;
    end
    if (got.snap_x !== want.snap_x) begin
      $display("%0t: snap_x expected %0d actual %0d", $time, want.snap_x, got.snap_x);
      errors++;
    end
    if (got.snap_y !== want.snap_y) begin
      $display("%0t: snap_y expected %0d actual %0d", $time, want.snap_y, got.snap_y);
      errors++;
    end
    if (got.snap_z !== want.snap_z) begin
      $display("%0t: snap_z expected %0d actual %0d", $time, want.snap_z, got.snap_z);
      errors++;
    end
    if (got.friction_out !== want.friction_out) begin
      $display("%0t: friction_out expected %0d actual %0d", $time, want.friction_out,
               got.friction_out);
      errors++;
    end
  endfunction

  // Driver: holds the payload while stalled, then waits a drawn gap before the next one.
  always @(posedge clk) begin
    bit held;
    bit next_valid;
    if (rst) begin
      item_valid <= 1'b0;
      gap_left = 0;
    end else begin
      held = item_valid && item_stall;
      next_valid = held;
      if (item_valid && !item_stall) begin
        track_collision(item);
        items_taken++;
      end
      if (!held) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending.size() > 0) begin
          item <= pending.pop_front();
          next_valid = 1'b1;
          gap_left = pick_wait();
        end
      end
      item_valid <= next_valid;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (result_valid && !result_stall) begin
        check_result(result);
        hold_left = pick_wait();
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles % 300 == 0) begin
      calm <= ($urandom_range(0, 3) == 0);
    end
    if (cycles > LIMIT) begin
      $display("** box_collision_snap: FAILED **");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    result_stall = 1'b0;
    calm = 1'b0;
    cycles = 0;
    errors = 0;
    items_queued = 0;
    items_taken = 0;
    results_seen = 0;
    results_hit = 0;
    for (int a = 0; a < 3; a++) begin
      mover_c[a] = 0;
      mover_h[a] = 0;
      prev_c[a] = 0;
      snap_c[a] = 0;
    end
    top_friction = 0;
    any_hit = 1'b0;

    queue_item(mk(ACT_UNUSED, 1'b1, -1, -1, -1, -1, -1, -1, -1, 1'b1, 1'b1));
    queue_item(mk(ACT_MOVER, KIND_SECTOR, 100, 200, 300, 10, 10, 10, 5, 1'b0, 1'b0));
    queue_item(mk(ACT_PREV, KIND_SECTOR, 90, 210, 300, -1, -1, -1, 0, 1'b0, 1'b0));
    queue_item(mk(ACT_OBSTACLE, KIND_BODY, 115, 195, 300, 10, 10, 10, 7, 1'b0, 1'b1));
    queue_item(mk(ACT_OBSTACLE, KIND_BODY, 120, 195, 300, 10, 10, 10, 100, 1'b0, 1'b1));
    queue_item(mk(ACT_OBSTACLE, KIND_SECTOR, 95, 130, 150, 205, 295, 400, -3, 1'b1, 1'b0));
    queue_item(mk(ACT_OBSTACLE, KIND_SECTOR, 0, 1000, 0, 1000, 0, 1000, 1000, 1'b1, 1'b0));
    queue_item(mk(ACT_OBSTACLE, KIND_SECTOR, 110, 200, 0, 400, 0, 100, 900, 1'b1, 1'b0));
    queue_item(mk(ACT_OBSTACLE, KIND_SECTOR, 50, 150, 150, 250, 305, 900, 50, 1'b0, 1'b1));
    queue_item(mk(ACT_UNUSED, KIND_SECTOR, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    queue_item(mk(ACT_MOVER, KIND_SECTOR, 32'h7fff_ff01, 32'h8000_0100, 0, 1000, 1000,
                  1000, 32'h7fff_ffff, 1'b0, 1'b0));
    queue_item(mk(ACT_PREV, KIND_SECTOR, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0, 0, 0,
                  1'b0, 1'b0));
    queue_item(mk(ACT_OBSTACLE, KIND_BODY, 32'h7fff_ffff, 32'h8000_0000, 0, 32'h7fff_ffff,
                  32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 1'b1, 1'b1));
    queue_item(mk(ACT_MOVER, KIND_BODY, 0, 0, 0, -5, -5, -5, 32'h8000_0000, 1'b1, 1'b0));
    queue_item(mk(ACT_PREV, KIND_BODY, -20, 20, 0, 32'h7fff_ffff, 32'h8000_0000, 0, 0,
                  1'b1, 1'b0));
    queue_item(mk(ACT_OBSTACLE, KIND_BODY, 3, 3, 3, 10, 10, 10, 32'h8000_0000, 1'b0, 1'b1));
    queue_item(mk(ACT_OBSTACLE, KIND_SECTOR, -100, 100, -100, 100, 50, 60, 32'h7fff_ffff,
                  1'b1, 1'b1));
    queue_item(mk(ACT_MOVER, KIND_BODY, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b0));
    queue_item(mk(ACT_OBSTACLE, KIND_SECTOR, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                  32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1, 1'b1));
    queue_item(mk(ACT_UNUSED, KIND_BODY, 0, 0, 0, 0, 0, 0, 0, 1'b1, 1'b1));

    while (items_queued < ITEM_GOAL) begin
      if ($urandom_range(0, 9) == 0) begin
        add_noise();
      end else begin
        add_query();
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (pending.size() > 0 || item_valid || snaps_due.size() > 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);

    $display("Ran %0d transactions through the block and checked %0d results,",
             items_taken, results_seen);
    $display("%0d of them reporting a collision.", results_hit);
    if (errors == 0) begin
      $display("** box_collision_snap: PASSED **");
    end else begin
      $display("** box_collision_snap: FAILED **");
    end
    $finish;
  end

endmodule
